// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the velocity profile checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, suspended while reset is low.
`define TVP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define TVP_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- src/tvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tvp_pkg
// Types and constants of the trapezoidal velocity profile generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tvp_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned NumAxes     = 6;
  localparam int unsigned DataW       = 32;

  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned ProdW       = DataW + $clog2(MaxSegments);
  localparam int unsigned RampShift   = FracBits + 4;
  localparam int unsigned CruiseShift = FracBits + 2;
  localparam int unsigned DvdW        = ProdW + RampShift;
  localparam int unsigned DenW        = DataW + $clog2(MaxSegments) + 2;
  localparam int unsigned RemW        = DenW + 1;
  localparam int unsigned StepW       = $clog2(DvdW);

  localparam logic [DataW-1:0] SatPos = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] SatNeg = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic        [6:0]  seg_count;
    logic        [31:0] total_duration;
  } req_t;

  typedef struct packed {
    logic        [5:0]  seg_index;
    logic        [31:0] seg_duration;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] omega_x;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_z;
    logic               last_seg;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic ramp;
    logic load;
    logic step;
    logic zero;
  } axis_ctrl_t;

  typedef struct packed {
    logic [DataW-1:0] quo;
    logic             ovf;
  } div_res_t;

endpackage

`default_nettype wire

// ----- src/tvp_serdiv.sv -----
// ----------------------------------------------------------------------------
// tvp_serdiv
// Bit-serial restoring divider: one quotient bit per cycle while step_i is high, MSB first,
// with a sticky flag for quotients that do not fit the result width.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_serdiv (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire logic                       step_i,
  input  wire logic [tvp_pkg::DvdW-1:0]   dividend_i,
  input  wire logic [tvp_pkg::DenW-1:0]   divisor_i,
  output tvp_pkg::div_res_t               res_o
);

  logic [tvp_pkg::DvdW-1:0]  dvd_q;
  logic [tvp_pkg::DenW-1:0]  rem_q, rem_d;
  logic [tvp_pkg::DataW-1:0] quo_q;
  logic                      ovf_q;
  logic [tvp_pkg::RemW-1:0]  rem_sh;
  logic [tvp_pkg::RemW:0]    diff;
  logic                      ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[tvp_pkg::DvdW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_i};
    ge     = ~diff[tvp_pkg::RemW];
    rem_d  = ge ? diff[tvp_pkg::DenW-1:0] : rem_sh[tvp_pkg::DenW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (step_i) begin
      dvd_q <= {dvd_q[tvp_pkg::DvdW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[tvp_pkg::DataW-2:0], ge};
      ovf_q <= ovf_q | quo_q[tvp_pkg::DataW-1];
    end
  end

  assign res_o.quo = quo_q;
  assign res_o.ovf = ovf_q;

endmodule

`default_nettype wire

// ----- src/tvp_axis.sv -----
// ----------------------------------------------------------------------------
// tvp_axis
// One velocity lane: holds the displacement magnitude and sign, forms the
// scaled numerator, divides it serially and saturates the signed result.
// ----------------------------------------------------------------------------
`default_nettype none

module tvp_axis (
  input  wire logic                       clk_i,
  input  wire tvp_pkg::axis_ctrl_t        ctrl_i,
  input  wire logic [tvp_pkg::DataW-1:0]  disp_i,
  input  wire logic [tvp_pkg::CntW-1:0]   k_i,
  input  wire logic [tvp_pkg::DenW-1:0]   den_i,
  output logic      [tvp_pkg::DataW-1:0]  vel_o
);

  logic                      neg_q;
  logic [tvp_pkg::DataW-1:0] mag_q;
  logic [tvp_pkg::ProdW-1:0] prod_q;
  logic [tvp_pkg::DvdW-1:0]  dividend;
  tvp_pkg::div_res_t         res;
  logic                      big;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      neg_q <= disp_i[tvp_pkg::DataW-1];
      mag_q <= disp_i[tvp_pkg::DataW-1] ? (tvp_pkg::DataW'(0) - disp_i) : disp_i;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= tvp_pkg::ProdW'(mag_q) * tvp_pkg::ProdW'(k_i);
    end
  end

  always_comb begin
    if (ctrl_i.ramp) begin
      dividend = tvp_pkg::DvdW'({prod_q, {tvp_pkg::RampShift{1'b0}}});
    end else begin
      dividend = tvp_pkg::DvdW'({prod_q, {tvp_pkg::CruiseShift{1'b0}}});
    end
  end

  tvp_serdiv u_div (
    .clk_i      (clk_i),
    .load_i     (ctrl_i.load),
    .step_i     (ctrl_i.step),
    .dividend_i (dividend),
    .divisor_i  (den_i),
    .res_o      (res)
  );

  always_comb begin
    big = res.ovf | (neg_q ? (res.quo > tvp_pkg::SatNeg) : (res.quo > tvp_pkg::SatPos));
    if (ctrl_i.zero) begin
      vel_o = '0;
    end else if (big) begin
      vel_o = neg_q ? tvp_pkg::SatNeg : tvp_pkg::SatPos;
    end else begin
      vel_o = neg_q ? (tvp_pkg::DataW'(0) - res.quo) : res.quo;
    end
  end

endmodule

`default_nettype wire

// ----- src/trapezoid_velocity_profile_gen_top.sv -----
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile_gen_top
// Turns one motion request into N segment beats carrying a trapezoidal
// velocity profile for three linear and three angular axes.
//
// Channel  Direction  Handshake                  Beat type
// in       input      in_valid_i / in_ready_o    tvp_pkg::req_t
// out      output     out_valid_o / out_ready_i  tvp_pkg::rsp_t
//
// After its accept, a request passes the denominator setup state; each segment
// then runs through the multiply, load, divide and emit states.
// Each segment is set by the bit-serial divide, one quotient bit per cycle in
// seven parallel dividers.
// Reset clears the sequencer and the output valid; there is no clearing pass.
// A stalled output holds the sequencer in its emit step; input is taken only
// while the sequencer is idle, even if the last beat still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_velocity_profile_gen_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire tvp_pkg::req_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output tvp_pkg::rsp_t out_data_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDen  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StLoad = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StEmit = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic [tvp_pkg::CntW-1:0]   n_q, n_d, seg_q, seg_d;
  logic [tvp_pkg::StepW-1:0]  cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic [tvp_pkg::DataW-1:0]  t_q;
  logic                       tzero_q;
  logic [tvp_pkg::DenW-1:0]   nt_q, den_q;
  tvp_pkg::rsp_t              out_q;

  logic                       in_acc, emit;
  logic [tvp_pkg::CntW-1:0]   n_in;
  logic [tvp_pkg::CntW:0]     n3;
  logic [tvp_pkg::CntW-1:0]   q1, k, seg_inc;
  logic [tvp_pkg::CntW:0]     q3;
  logic                       ramp, last;
  tvp_pkg::axis_ctrl_t        ctrl;
  tvp_pkg::div_res_t          dur_res;
  logic [tvp_pkg::DataW-1:0]  disp_in [tvp_pkg::NumAxes];
  logic [tvp_pkg::DataW-1:0]  vel     [tvp_pkg::NumAxes];

  assign in_ready_o  = (state_q == StIdle);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    n_in = tvp_pkg::CntW'(in_data_i.seg_count);
    if (n_in > tvp_pkg::CntW'(tvp_pkg::MaxSegments)) begin
      n_in = tvp_pkg::CntW'(tvp_pkg::MaxSegments);
    end
  end

  always_comb begin
    q1      = n_q >> 2;
    n3      = {n_q, 1'b0} + {1'b0, n_q};
    q3      = n3 >> 2;
    seg_inc = seg_q + tvp_pkg::CntW'(1);
    last    = (seg_inc == n_q);
    if (seg_q < q1) begin
      ramp = 1'b1;
      k    = seg_inc;
    end else if ({1'b0, seg_q} < q3) begin
      ramp = 1'b0;
      k    = n_q;
    end else begin
      ramp = 1'b1;
      k    = n_q - seg_inc;
    end
  end

  always_comb begin
    ctrl.capture = in_acc;
    ctrl.mul_en  = (state_q == StMul);
    ctrl.ramp    = ramp;
    ctrl.load    = (state_q == StLoad);
    ctrl.step    = (state_q == StDiv);
    ctrl.zero    = tzero_q;
  end

  assign disp_in[0] = in_data_i.disp_x;
  assign disp_in[1] = in_data_i.disp_y;
  assign disp_in[2] = in_data_i.disp_z;
  assign disp_in[3] = in_data_i.rot_x;
  assign disp_in[4] = in_data_i.rot_y;
  assign disp_in[5] = in_data_i.rot_z;

  for (genvar a = 0; a < tvp_pkg::NumAxes; a++) begin : g_axis
    tvp_axis u_axis (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .disp_i (disp_in[a]),
      .k_i    (k),
      .den_i  (den_q),
      .vel_o  (vel[a])
    );
  end

  tvp_serdiv u_dur (
    .clk_i      (clk_i),
    .load_i     (ctrl.load),
    .step_i     (ctrl.step),
    .dividend_i (tvp_pkg::DvdW'(t_q)),
    .divisor_i  (tvp_pkg::DenW'(n_q)),
    .res_o      (dur_res)
  );

  assign emit = (state_q == StEmit) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    seg_d       = seg_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          n_d   = n_in;
          seg_d = '0;
          if (n_in != '0) begin
            state_d = StDen;
          end
        end
      end
      StDen: begin
        state_d = StMul;
      end
      StMul: begin
        state_d = StLoad;
      end
      StLoad: begin
        cnt_d   = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cnt_d = cnt_q + tvp_pkg::StepW'(1);
        if (cnt_q == tvp_pkg::StepW'(tvp_pkg::DvdW - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit) begin
          out_valid_d = 1'b1;
          if (last) begin
            state_d = StIdle;
          end else begin
            seg_d   = seg_inc;
            state_d = StMul;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      n_q         <= '0;
      seg_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      seg_q       <= seg_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      t_q     <= in_data_i.total_duration;
      tzero_q <= (in_data_i.total_duration == '0);
      nt_q    <= tvp_pkg::DenW'(n_in) * tvp_pkg::DenW'(in_data_i.total_duration);
    end
    if (state_q == StDen) begin
      den_q <= {nt_q[tvp_pkg::DenW-2:0], 1'b0} + nt_q;
    end
    if (emit) begin
      out_q.seg_index    <= 6'(seg_q);
      out_q.seg_duration <= dur_res.quo;
      out_q.vel_x        <= vel[0];
      out_q.vel_y        <= vel[1];
      out_q.vel_z        <= vel[2];
      out_q.omega_x      <= vel[3];
      out_q.omega_y      <= vel[4];
      out_q.omega_z      <= vel[5];
      out_q.last_seg     <= last;
    end
  end

endmodule

`default_nettype wire

// ----- src/tvp_checker.sv -----
// ----------------------------------------------------------------------------
// tvp_checker
// Port-level checks of the velocity profile generator: beat ordering,
// constant segment duration within a request, output stall behavior and busy input ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tvp_checker (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire tvp_pkg::req_t in_data_i,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire tvp_pkg::rsp_t out_data_o
);

  logic [5:0]  exp_idx_q;
  logic [31:0] dur_q;
  logic        out_acc;

  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      dur_q     <= '0;
    end else if (out_acc) begin
      exp_idx_q <= out_data_o.last_seg ? 6'd0 : out_data_o.seg_index + 6'd1;
      dur_q     <= out_data_o.seg_duration;
    end
  end

  `TVP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  `TVP_ASSERT(a_idx_order, clk_i, rst_ni, out_valid_o |-> out_data_o.seg_index == exp_idx_q)
  `TVP_ASSERT(a_dur_const, clk_i, rst_ni, out_valid_o && exp_idx_q != 6'd0 |-> out_data_o.seg_duration == dur_q)
  `TVP_NEVER(a_busy_ready, clk_i, rst_ni, $past(in_valid_i && in_ready_o && in_data_i.seg_count != 7'd0) && in_ready_o)

endmodule

bind trapezoid_velocity_profile_gen_top tvp_checker u_tvp_checker (.*);

`default_nettype wire

// ----- sim/tb_trapezoid_velocity_profile_gen_top.sv -----
// ----------------------------------------------------------------------------
// tb_trapezoid_velocity_profile_gen_top
// Self-checking bench for the trapezoidal velocity profile generator. A short
// table of directed requests is followed by random requests. Every accepted
// request is expanded into its segment beats, from the expected values of its
// table row or by a bit-exact profile predictor, and each output beat is compared
// field by field with the oldest pending segment. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trapezoid_velocity_profile_gen_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned SetupCycles = 3;
  localparam int unsigned SegCycles   = 61;
  localparam int unsigned MaxGap      = 40;
  localparam int unsigned RandomReqs  = 202;
  localparam int unsigned DrainCycles =
    SetupCycles + tvp_pkg::MaxSegments * SegCycles + 100;
  localparam longint unsigned LimitNs =
    longint'(ClkPeriod) * 4 * 250 *
    (SetupCycles + tvp_pkg::MaxSegments * (SegCycles + MaxGap) + MaxGap);

  typedef struct {
    bit            typed;
    tvp_pkg::req_t req;
    logic [31:0]   want_dur;
    logic [31:0]   want_vel;
  } stim_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  tvp_pkg::req_t in_data_i   = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  tvp_pkg::rsp_t out_data_o;

  tvp_pkg::rsp_t pending_segs[$];
  stim_row_t     directed[$];
  int            errors     = 0;
  int            stall_left = 0;
  bit            no_idle    = 1'b0;

  trapezoid_velocity_profile_gen_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [31:0] profile_velocity(logic [31:0] d, int unsigned c,
                                                   int unsigned k, int unsigned n,
                                                   logic [31:0] t);
    bit neg;
    longint unsigned mag, num, den, q, r, cap, limit;
    neg = d[31];
    mag = neg ? (64'h1_0000_0000 - longint'(d)) : longint'(d);
    num = longint'(c) * mag * longint'(k);
    den = 64'd3 * longint'(n) * longint'(t);
    if (t == 0 || n == 0 || num == 0) begin
      return 32'd0;
    end
    cap = 64'h2_0000_0000;
    q = num / den;
    r = num % den;
    if (q > cap) q = cap;
    for (int s = 0; s < tvp_pkg::FracBits; s++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r = r - den;
        q = q + 1;
      end
      if (q > cap) q = cap;
    end
    limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (q > limit) q = limit;
    return neg ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  function automatic tvp_pkg::req_t build_req(logic [31:0] dx, logic [31:0] dy,
                                              logic [31:0] dz, logic [31:0] rx,
                                              logic [31:0] ry, logic [31:0] rz,
                                              logic [6:0] n, logic [31:0] t);
    tvp_pkg::req_t r;
    r.disp_x         = dx;
    r.disp_y         = dy;
    r.disp_z         = dz;
    r.rot_x          = rx;
    r.rot_y          = ry;
    r.rot_z          = rz;
    r.seg_count      = n;
    r.total_duration = t;
    return r;
  endfunction

  function automatic logic [31:0] random_disp();
    int unsigned p;
    logic [31:0] v;
    p = $urandom_range(0, 99);
    if (p < 60) begin
      v = $urandom;
    end else if (p < 80) begin
      v = $urandom_range(0, 32'h3_FFFF);
      if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    end else if (p < 90) begin
      v = ($urandom_range(0, 1) == 1) ? tvp_pkg::SatPos : tvp_pkg::SatNeg;
    end else begin
      v = 32'd0;
    end
    return v;
  endfunction

  function automatic logic [31:0] random_duration();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return $urandom;
    if (p < 70) return $urandom_range(1, 32'hFFFF);
    if (p < 90) return $urandom_range(32'h1_0000, 32'hF_FFFF);
    if (p < 95) return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [6:0] random_count();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 7'd0;
    if (p < 70) return 7'($urandom_range(1, 8));
    if (p < 90) return 7'($urandom_range(9, 32));
    if (p < 97) return 7'($urandom_range(33, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  function automatic int pick_gap();
    int unsigned p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, MaxGap);
  endfunction

  task automatic queue_profile(input stim_row_t row);
    int unsigned n, q1, q3, c, k;
    logic [31:0] t, dur;
    logic [31:0] d[6];
    logic [31:0] v[6];
    tvp_pkg::rsp_t seg;
    n = row.req.seg_count;
    if (n > tvp_pkg::MaxSegments) n = tvp_pkg::MaxSegments;
    t = row.req.total_duration;
    d = '{row.req.disp_x, row.req.disp_y, row.req.disp_z,
          row.req.rot_x, row.req.rot_y, row.req.rot_z};
    q1 = n / 4;
    q3 = (3 * n) / 4;
    dur = (t == 0 || n == 0) ? 32'd0 : t / n;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < q1) begin
        c = 16;
        k = i + 1;
      end else if (i < q3) begin
        c = 4;
        k = n;
      end else begin
        c = 16;
        k = n - i - 1;
      end
      for (int a = 0; a < 6; a++) begin
        if (row.typed) v[a] = (i + 1 == n) ? 32'd0 : row.want_vel;
        else v[a] = profile_velocity(d[a], c, k, n, t);
      end
      seg.seg_index    = i[5:0];
      seg.seg_duration = row.typed ? row.want_dur : dur;
      seg.vel_x        = v[0];
      seg.vel_y        = v[1];
      seg.vel_z        = v[2];
      seg.omega_x      = v[3];
      seg.omega_y      = v[4];
      seg.omega_z      = v[5];
      seg.last_seg     = (i + 1 == n);
      pending_segs.push_back(seg);
    end
  endtask

  task automatic send_req(input stim_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= row.req;
    do @(posedge clk_i); while (!in_ready_o);
    queue_profile(row);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, input int idx);
    if (want !== got) begin
      flag_error($sformatf("segment %0d %s: expected %h, got %h", idx, name, want, got));
    end
  endtask

  task automatic check_segment(input tvp_pkg::rsp_t got);
    tvp_pkg::rsp_t want;
    if (pending_segs.size() == 0) begin
      flag_error($sformatf("unexpected beat, segment %0d", got.seg_index));
    end else begin
      want = pending_segs.pop_front();
      compare_field("seg_index", 32'(want.seg_index), 32'(got.seg_index), want.seg_index);
      compare_field("seg_duration", want.seg_duration, got.seg_duration, want.seg_index);
      compare_field("vel_x", want.vel_x, got.vel_x, want.seg_index);
      compare_field("vel_y", want.vel_y, got.vel_y, want.seg_index);
      compare_field("vel_z", want.vel_z, got.vel_z, want.seg_index);
      compare_field("omega_x", want.omega_x, got.omega_x, want.seg_index);
      compare_field("omega_y", want.omega_y, got.omega_y, want.seg_index);
      compare_field("omega_z", want.omega_z, got.omega_z, want.seg_index);
      compare_field("last_seg", 32'(want.last_seg), 32'(got.last_seg), want.seg_index);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_segment(out_data_o);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    stim_row_t row;
    directed.push_back('{1'b1, build_req(0, 0, 0, 0, 0, 0, 7'd4, 32'h1_0000),
                         32'h4000, 32'd0});
    directed.push_back('{1'b1, build_req(32'h1234_5678, tvp_pkg::SatNeg, 1, 2, 3, 4,
                                         7'd0, 32'h1_0000), 32'd0, 32'd0});
    directed.push_back('{1'b1, build_req(tvp_pkg::SatPos, tvp_pkg::SatPos, tvp_pkg::SatPos,
                                         tvp_pkg::SatNeg, tvp_pkg::SatNeg, tvp_pkg::SatNeg,
                                         7'd8, 32'd0), 32'd0, 32'd0});
    directed.push_back('{1'b1, build_req(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                                         32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                                         7'd1, 32'h3_0000), 32'h3_0000, 32'd0});
    directed.push_back('{1'b1, build_req(tvp_pkg::SatPos, tvp_pkg::SatPos, tvp_pkg::SatPos,
                                         tvp_pkg::SatPos, tvp_pkg::SatPos, tvp_pkg::SatPos,
                                         7'd2, 32'd1), 32'd0, tvp_pkg::SatPos});
    directed.push_back('{1'b1, build_req(tvp_pkg::SatNeg, tvp_pkg::SatNeg, tvp_pkg::SatNeg,
                                         tvp_pkg::SatNeg, tvp_pkg::SatNeg, tvp_pkg::SatNeg,
                                         7'd2, 32'd1), 32'd0, tvp_pkg::SatNeg});
    directed.push_back('{1'b0, build_req(tvp_pkg::SatPos, tvp_pkg::SatNeg, 32'h0001_0000,
                                         32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF,
                                         7'd64, 32'hFFFF_FFFF), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000,
                                         32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE,
                                         7'd127, 32'h0004_0000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0002_0000, 32'hFFFE_0000, 32'h0000_1000,
                                         32'h0100_0000, 32'hFF00_0000, 32'h0000_0003,
                                         7'd65, 32'h0002_0000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0001,
                                         32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFE_8000,
                                         7'd3, 32'h0001_0000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0001,
                                         32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFE_8000,
                                         7'd4, 32'h0001_0000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0007_3333, 32'hFFF8_CCCD, 32'h0000_0100,
                                         32'h0003_243F, 32'hFFFC_DBC1, 32'h0000_0000,
                                         7'd5, 32'h0002_8000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0007_3333, 32'hFFF8_CCCD, 32'h0000_0100,
                                         32'h0003_243F, 32'hFFFC_DBC1, 32'h0000_0000,
                                         7'd6, 32'h0002_8000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0007_3333, 32'hFFF8_CCCD, 32'h0000_0100,
                                         32'h0003_243F, 32'hFFFC_DBC1, 32'h0000_0000,
                                         7'd7, 32'h0002_8000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                         32'd1, 32'd1, 32'd1, 7'd8, 32'd1), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'h0064_0000, 32'hFF9C_0000, 32'h0032_0000,
                                         32'hFFCE_0000, 32'h0001_0000, 32'hFFFF_0000,
                                         7'd16, 32'h0001_0000), 32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(tvp_pkg::SatPos, tvp_pkg::SatNeg, 32'h0001_0000,
                                         32'hFFFF_0000, 32'd0, 32'd1, 7'd100, 32'd0),
                         32'd0, 32'd0});
    directed.push_back('{1'b0, build_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
                                         32'h0F0F_0F0F, 32'hCCCC_CCCC, 32'h3333_3333,
                                         7'd12, 32'h0000_0003), 32'd0, 32'd0});

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[j]) send_req(directed[j]);

    for (int j = 0; j < RandomReqs; j++) begin
      no_idle = (j % 40) >= 30;
      row.typed    = 1'b0;
      row.want_dur = 32'd0;
      row.want_vel = 32'd0;
      row.req = build_req(random_disp(), random_disp(), random_disp(), random_disp(),
                          random_disp(), random_disp(), random_count(), random_duration());
      send_req(row);
    end
    in_valid_i <= 1'b0;
    no_idle = 1'b0;

    while (pending_segs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(LimitNs * 1ns);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- trapezoid_velocity_profile_gen_top.f -----
+incdir+src
src/tvp_pkg.sv
src/tvp_serdiv.sv
src/tvp_axis.sv
src/trapezoid_velocity_profile_gen_top.sv
src/tvp_checker.sv
sim/tb_trapezoid_velocity_profile_gen_top.sv
